// ===== src/haversine_great_circle_distance_defines.svh =====
// Assertion macros for the haversine distance block.
// Used by the top level; compiled out when SYNTHESIS is defined.
`ifndef HAVERSINE_GREAT_CIRCLE_DISTANCE_DEFINES_SVH
`define HAVERSINE_GREAT_CIRCLE_DISTANCE_DEFINES_SVH
`ifndef SYNTHESIS
`define HAV_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
`define HAV_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define HAV_ASSERT_IMP(label, clk, rstn, ante, cons)
`define HAV_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== src/hav_pkg.sv =====
// Shared constants, tables and types of the haversine distance datapath.
// No dependencies; imported by every module of the block.
package hav_pkg;

  localparam int ANGLE_FRAC_BITS = 22;
  localparam int CORDIC_STEPS    = 30;
  localparam int CW              = 33;  // CORDIC datapath width, signed
  localparam int RAD_W           = 31;  // radians Q30, unsigned
  localparam int ROOT_W          = 31;
  localparam int SQ_W            = 61;
  localparam int RADIUS_W        = 16;
  localparam int DIST_W          = 34;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd6371;
  localparam logic [CW-1:0]       INV_GAIN     = 33'd652032874;
  localparam logic [27:0]         PI_Q26       = 28'd210828714;
  // ceil(2^43 / 45): exact floor division by 45 for 37-bit operands
  localparam logic [37:0]         RECIP_45     = 38'd195468733827;
  localparam int                  RECIP_SHIFT  = 43;
  localparam logic [RAD_W-1:0]    ONE_Q30      = 31'd1073741824;

  localparam logic [30:0] FULL_TURN    = 31'(360 << ANGLE_FRAC_BITS);
  localparam logic [30:0] HALF_TURN    = 31'(180 << ANGLE_FRAC_BITS);
  localparam logic [30:0] QUARTER_TURN = 31'(90 << ANGLE_FRAC_BITS);

  localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535,
    30'd32767, 30'd16383, 30'd8191, 30'd4095, 30'd2047,
    30'd1023, 30'd511, 30'd255, 30'd127, 30'd63,
    30'd31, 30'd15, 30'd8, 30'd4, 30'd2
  };

  typedef logic signed [CW-1:0] cw_t;

endpackage

// ===== src/hav_prep.sv =====
// Angle lane: reduces a degree angle modulo 360, folds it into the first quadrant
// (cosine lanes) or half turn (sine lanes, then halved) and converts to radians Q30.
// Depends on hav_pkg.
module hav_prep
  import hav_pkg::*;
#(
  parameter bit COS_MODE = 1'b0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [31:0]      angle_i,
  output logic                    valid_o,
  output logic [RAD_W-1:0]        rad_o,
  output logic                    neg_o
);

  localparam int SH = COS_MODE ? ANGLE_FRAC_BITS - 2 : ANGLE_FRAC_BITS - 1;
  localparam logic [57:0] ROUND_ADD = 58'(45) << (SH - 1);
  localparam logic signed [33:0] FULL_S = 34'(FULL_TURN);

  logic [5:0]  v_q;
  logic [30:0] r1_d, r1_q;
  logic [29:0] r2_d, r2_q;
  logic [29:0] r3_d, r3_q;
  logic        n3_d, n3_q, n4_q, n5_q, n6_q;
  logic [57:0] p_d, p_q;
  logic [36:0] m;
  logic [55:0] pph_d, pph_q;
  logic [56:0] ppl_d, ppl_q;
  logic [75:0] sum;
  logic [RAD_W-1:0] rad_d, rad_q;
  logic signed [33:0] v;

  always_comb begin
    v = 34'(angle_i);
    if (v < -FULL_S) begin
      r1_d = 31'(v + FULL_S + FULL_S);
    end else if (v < 0) begin
      r1_d = 31'(v + FULL_S);
    end else if (v >= FULL_S) begin
      r1_d = 31'(v - FULL_S);
    end else begin
      r1_d = 31'(v);
    end
  end

  assign r2_d = (r1_q > HALF_TURN) ? 30'(FULL_TURN - r1_q) : 30'(r1_q);

  always_comb begin
    r3_d = r2_q;
    n3_d = 1'b0;
    if (COS_MODE && (r2_q > 30'(QUARTER_TURN))) begin
      r3_d = 30'(HALF_TURN) - r2_q;
      n3_d = 1'b1;
    end
  end

  assign p_d   = 58'(r3_q) * 58'(PI_Q26) + ROUND_ADD;
  assign m     = 37'(p_q >> SH);
  assign ppl_d = 57'(m[18:0]) * 57'(RECIP_45);
  assign pph_d = 56'(m[36:19]) * 56'(RECIP_45);
  assign sum   = {1'b0, pph_q, 19'd0} + 76'(ppl_q);
  assign rad_d = RAD_W'(sum >> RECIP_SHIFT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q  <= r1_d;
      r2_q  <= r2_d;
      r3_q  <= r3_d;
      n3_q  <= n3_d;
      p_q   <= p_d;
      n4_q  <= n3_q;
      ppl_q <= ppl_d;
      pph_q <= pph_d;
      n5_q  <= n4_q;
      rad_q <= rad_d;
      n6_q  <= n5_q;
    end
  end

  assign valid_o = v_q[5];
  assign rad_o   = rad_q;
  assign neg_o   = n6_q;

endmodule

// ===== src/hav_rot.sv =====
// Rotation-mode CORDIC, one iteration per register stage.
// Gives cos and sin in Q30 of an angle in [0, pi/2]. Depends on hav_pkg.
module hav_rot
  import hav_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [RAD_W-1:0] z_i,
  input  logic             tag_i,
  output logic             valid_o,
  output cw_t              x_o,
  output cw_t              y_o,
  output logic             tag_o
);

  cw_t  x_q [CORDIC_STEPS];
  cw_t  y_q [CORDIC_STEPS];
  cw_t  z_q [CORDIC_STEPS];
  logic t_q [CORDIC_STEPS];
  logic v_q [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    cw_t  x_in, y_in, z_in, xs, ys, at;
    logic t_in, v_in;

    if (i == 0) begin : g_first
      assign x_in = cw_t'(INV_GAIN);
      assign y_in = '0;
      assign z_in = cw_t'(z_i);
      assign t_in = tag_i;
      assign v_in = valid_i;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
      assign t_in = t_q[i-1];
      assign v_in = v_q[i-1];
    end

    assign xs = x_in >>> i;
    assign ys = y_in >>> i;
    assign at = cw_t'(ATAN_TAB[i]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t_q[i] <= t_in;
        if (!z_in[CW-1]) begin
          x_q[i] <= x_in - ys;
          y_q[i] <= y_in + xs;
          z_q[i] <= z_in - at;
        end else begin
          x_q[i] <= x_in + ys;
          y_q[i] <= y_in - xs;
          z_q[i] <= z_in + at;
        end
      end
    end
  end

  assign valid_o = v_q[CORDIC_STEPS-1];
  assign x_o     = x_q[CORDIC_STEPS-1];
  assign y_o     = y_q[CORDIC_STEPS-1];
  assign tag_o   = t_q[CORDIC_STEPS-1];

endmodule

// ===== src/hav_sqrt.sv =====
// Pipelined floor square root, one result bit per register stage.
// Depends on hav_pkg for the operand and root widths.
module hav_sqrt
  import hav_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [SQ_W-1:0]   n_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o
);

  logic [SQ_W-1:0]   rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic              v_q    [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_bit
    localparam int B = ROOT_W - 1 - s;
    logic [SQ_W-1:0]   rem_in;
    logic [ROOT_W-1:0] root_in;
    logic              v_in;
    logic [SQ_W+1:0]   trial;

    if (s == 0) begin : g_first
      assign rem_in  = n_i;
      assign root_in = '0;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign v_in    = v_q[s-1];
    end

    // root bits below B+1 are still zero, so OR acts as add
    assign trial = ((SQ_W+2)'(root_in) << (B + 1)) | ((SQ_W+2)'(1) << (2 * B));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if ((SQ_W+2)'(rem_in) >= trial) begin
          rem_q[s]  <= rem_in - SQ_W'(trial);
          root_q[s] <= root_in | (ROOT_W'(1) << B);
        end else begin
          rem_q[s]  <= rem_in;
          root_q[s] <= root_in;
        end
      end
    end
  end

  assign valid_o = v_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];

endmodule

// ===== src/hav_vec.sv =====
// Vectoring-mode CORDIC, one iteration per register stage.
// Gives atan2(y, x) in Q30 for x, y >= 0, clamped at zero. Depends on hav_pkg.
module hav_vec
  import hav_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [ROOT_W-1:0] x_i,
  input  logic [ROOT_W-1:0] y_i,
  output logic              valid_o,
  output logic [RAD_W-1:0]  ang_o
);

  cw_t  x_q [CORDIC_STEPS];
  cw_t  y_q [CORDIC_STEPS];
  cw_t  z_q [CORDIC_STEPS];
  logic v_q [CORDIC_STEPS];
  cw_t  z_last;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    cw_t  x_in, y_in, z_in, xs, ys, at;
    logic v_in, up;

    if (i == 0) begin : g_first
      assign x_in = cw_t'(x_i);
      assign y_in = cw_t'(y_i);
      assign z_in = '0;
      assign v_in = valid_i;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
      assign v_in = v_q[i-1];
    end

    assign xs = x_in >>> i;
    assign ys = y_in >>> i;
    assign at = cw_t'(ATAN_TAB[i]);
    assign up = !y_in[CW-1] && (y_in != '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (up) begin
          x_q[i] <= x_in + ys;
          y_q[i] <= y_in - xs;
          z_q[i] <= z_in + at;
        end else begin
          x_q[i] <= x_in - ys;
          y_q[i] <= y_in + xs;
          z_q[i] <= z_in - at;
        end
      end
    end
  end

  assign z_last  = z_q[CORDIC_STEPS-1];
  assign valid_o = v_q[CORDIC_STEPS-1];
  assign ang_o   = z_last[CW-1] ? '0 : RAD_W'(z_last);

endmodule

// ===== src/haversine_great_circle_distance.sv =====
// Great-circle distance between two points by the haversine formula.
// Input channel (in_valid_i/in_ready_o): one request carries lat_a, lon_a,
// lat_b, lon_b in signed degrees with 22 fraction bits. Output channel
// (out_valid_o/out_ready_i): one arc_distance per request, unsigned Q18.16 in
// units of the sphere radius. Config channel (cfg_valid_i/cfg_ready_o):
// earth_radius_i, always ready; write it only while no request is in flight.
// The pipeline has 103 register stages: input difference (1), angle reduction
// and radian conversion (6), rotation CORDIC (30), haversine products and
// clamp (4), square roots (31), vectoring CORDIC (30), output register (1).
// Throughput is one request per cycle while the skid register is empty.
// A one-entry skid register sits behind the output register: when the
// receiver stalls, one more result is caught there, after which the whole
// pipeline holds and in_ready_o drops until the skid drains.
// Reset empties the pipeline and sets the radius to 6371 (kilometers).
// Depends on hav_pkg, hav_prep, hav_rot, hav_sqrt, hav_vec and the defines header.
`include "haversine_great_circle_distance_defines.svh"

module haversine_great_circle_distance
  import hav_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [29:0]  lat_a_i,
  input  logic signed [30:0]  lon_a_i,
  input  logic signed [29:0]  lat_b_i,
  input  logic signed [30:0]  lon_b_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DIST_W-1:0]   arc_distance_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [RADIUS_W-1:0] earth_radius_i
);

  logic en;
  logic [RADIUS_W-1:0] radius_q;

  // input differences
  logic               d_v_q;
  logic signed [30:0] dlat_q;
  logic signed [31:0] dlon_q;
  logic signed [29:0] la_q, lb_q;

  logic             pv_lat, pn_ca, pn_cb;
  logic [RAD_W-1:0] pr_lat, pr_lon, pr_ca, pr_cb;
  logic             rv_lat, rt_ca, rt_cb;
  cw_t              rx_ca, rx_cb, ry_lat, ry_lon;

  // haversine stages
  logic [3:0]         h_v_q;
  cw_t                sl_q, so_q, ca_q, cb_q;
  logic signed [63:0] m_lat, m_lon, m_cc, m_t;
  logic signed [33:0] slat1_q, slon1_q, cc1_q, slat2_q, t2_q;
  logic signed [34:0] h_sum;
  logic [RAD_W-1:0]   h_d, h_q;

  logic              sv_sn;
  logic [ROOT_W-1:0] sn, cs;
  logic              av;
  logic [RAD_W-1:0]  ang;

  logic [48:0]       dist_full;
  logic [DIST_W-1:0] dist_rnd;
  logic              pipe_take;

  logic              out_v_q, sk_v_q;
  logic [DIST_W-1:0] out_q, sk_q;

  assign en          = !sk_v_q;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (cfg_valid_i) begin
      radius_q <= earth_radius_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
      h_v_q <= '0;
    end else if (en) begin
      d_v_q <= in_valid_i;
      h_v_q <= {h_v_q[2:0], rv_lat};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dlat_q <= 31'(lat_b_i) - 31'(lat_a_i);
      dlon_q <= 32'(lon_b_i) - 32'(lon_a_i);
      la_q   <= lat_a_i;
      lb_q   <= lat_b_i;
    end
  end

  hav_prep #(.COS_MODE(1'b0)) u_prep_lat (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d_v_q), .angle_i(32'(dlat_q)),
    .valid_o(pv_lat), .rad_o(pr_lat), .neg_o()
  );
  hav_prep #(.COS_MODE(1'b0)) u_prep_lon (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d_v_q), .angle_i(dlon_q),
    .valid_o(), .rad_o(pr_lon), .neg_o()
  );
  hav_prep #(.COS_MODE(1'b1)) u_prep_ca (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d_v_q), .angle_i(32'(la_q)),
    .valid_o(), .rad_o(pr_ca), .neg_o(pn_ca)
  );
  hav_prep #(.COS_MODE(1'b1)) u_prep_cb (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d_v_q), .angle_i(32'(lb_q)),
    .valid_o(), .rad_o(pr_cb), .neg_o(pn_cb)
  );

  hav_rot u_rot_lat (
    .clk_i, .rst_ni, .en_i(en), .valid_i(pv_lat), .z_i(pr_lat), .tag_i(1'b0),
    .valid_o(rv_lat), .x_o(), .y_o(ry_lat), .tag_o()
  );
  hav_rot u_rot_lon (
    .clk_i, .rst_ni, .en_i(en), .valid_i(pv_lat), .z_i(pr_lon), .tag_i(1'b0),
    .valid_o(), .x_o(), .y_o(ry_lon), .tag_o()
  );
  hav_rot u_rot_ca (
    .clk_i, .rst_ni, .en_i(en), .valid_i(pv_lat), .z_i(pr_ca), .tag_i(pn_ca),
    .valid_o(), .x_o(rx_ca), .y_o(), .tag_o(rt_ca)
  );
  hav_rot u_rot_cb (
    .clk_i, .rst_ni, .en_i(en), .valid_i(pv_lat), .z_i(pr_cb), .tag_i(pn_cb),
    .valid_o(), .x_o(rx_cb), .y_o(), .tag_o(rt_cb)
  );

  // apply the quadrant sign, then square and multiply in Q30
  assign m_lat = signed'(sl_q[31:0]) * signed'(sl_q[31:0]);
  assign m_lon = signed'(so_q[31:0]) * signed'(so_q[31:0]);
  assign m_cc  = signed'(ca_q[31:0]) * signed'(cb_q[31:0]);
  assign m_t   = signed'(cc1_q[31:0]) * signed'(slon1_q[31:0]);
  assign h_sum = 35'(slat2_q) + 35'(t2_q);

  always_comb begin
    if (h_sum < 0) begin
      h_d = '0;
    end else if (h_sum > 35'(ONE_Q30)) begin
      h_d = ONE_Q30;
    end else begin
      h_d = RAD_W'(h_sum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sl_q    <= ry_lat;
      so_q    <= ry_lon;
      ca_q    <= rt_ca ? -rx_ca : rx_ca;
      cb_q    <= rt_cb ? -rx_cb : rx_cb;
      slat1_q <= 34'(m_lat >>> 30);
      slon1_q <= 34'(m_lon >>> 30);
      cc1_q   <= 34'(m_cc >>> 30);
      slat2_q <= slat1_q;
      t2_q    <= 34'(m_t >>> 30);
      h_q     <= h_d;
    end
  end

  hav_sqrt u_sqrt_sn (
    .clk_i, .rst_ni, .en_i(en), .valid_i(h_v_q[3]), .n_i({h_q, 30'd0}),
    .valid_o(sv_sn), .root_o(sn)
  );
  hav_sqrt u_sqrt_cs (
    .clk_i, .rst_ni, .en_i(en), .valid_i(h_v_q[3]), .n_i({ONE_Q30 - h_q, 30'd0}),
    .valid_o(), .root_o(cs)
  );

  hav_vec u_vec (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sv_sn), .x_i(cs), .y_i(sn),
    .valid_o(av), .ang_o(ang)
  );

  // 2 * R * angle, Q30 -> Q18.16 rounded half up
  assign dist_full = 49'({radius_q, 1'b0}) * 49'(ang) + 49'(1 << 13);
  assign dist_rnd  = DIST_W'(dist_full >> 14);
  assign pipe_take = en && av;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      if (sk_v_q) begin
        out_v_q <= 1'b1;
        sk_v_q  <= 1'b0;
      end else begin
        out_v_q <= pipe_take;
      end
    end else if (pipe_take) begin
      sk_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_ready_i) begin
      out_q <= sk_v_q ? sk_q : dist_rnd;
    end else if (pipe_take) begin
      sk_q <= dist_rnd;
    end
  end

  assign out_valid_o    = out_v_q;
  assign arc_distance_o = out_q;

  `HAV_ASSERT_IMP(a_skid_behind_out, clk_i, rst_ni, sk_v_q, out_v_q)
  `HAV_ASSERT_NXT(a_skid_catches, clk_i, rst_ni, out_v_q && !out_ready_i && pipe_take, sk_v_q)
  `HAV_ASSERT_NXT(a_skid_drains, clk_i, rst_ni, sk_v_q && out_ready_i, !sk_v_q && out_v_q)

endmodule

// ===== tb/haversine_great_circle_distance_test.sv =====
// Testbench for the haversine great-circle distance block: random and corner
// point pairs against a fixed-point predictor. Depends on hav_pkg and the DUT.
module haversine_great_circle_distance_test
  import hav_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint LAT_MAX = 377487360;
  localparam longint LON_MAX = 754974720;
  localparam int     PIPE_LAT = 103;

  typedef struct packed {
    logic signed [29:0] lat_a;
    logic signed [30:0] lon_a;
    logic signed [29:0] lat_b;
    logic signed [30:0] lon_b;
  } point_pair_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  localparam logic [RADIUS_W-1:0] RADII [6] = '{
    16'd6371, 16'd1, 16'd65535, 16'd3956, 16'd0, 16'd6371
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [29:0] lat_a_i = '0;
  logic signed [30:0] lon_a_i = '0;
  logic signed [29:0] lat_b_i = '0;
  logic signed [30:0] lon_b_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [DIST_W-1:0] arc_distance_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [RADIUS_W-1:0] earth_radius_i = '0;

  haversine_great_circle_distance DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  point_pair_t pending_q[$];
  logic [DIST_W-1:0] dist_q[$];
  logic [RADIUS_W-1:0] radius = RADIUS_RESET;
  idle_mode_e idle_mode = IDLE_NONE;
  bit hold_send = 1'b0;
  int mismatches = 0;
  // set when the presented request was taken at the last rising edge
  bit in_ready_o_seen = 1'b0;

  localparam longint ATAN[30] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
    15, 8, 4, 2
  };

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint wrap_turn(longint v);
    longint full, r;
    full = 64'd360 << ANGLE_FRAC_BITS;
    r = v % full;
    if (r < 0) r += full;
    return r;
  endfunction

  function automatic longint deg_to_rad(longint deg, int down);
    longint unsigned dv;
    dv = 64'd45 << (ANGLE_FRAC_BITS - down);
    return longint'((longint'(deg) * 64'd210828714 + dv / 2) / dv);
  endfunction

  function automatic void cordic_rotate(input longint z, output longint c,
                                        output longint s);
    longint x, y, xs, ys;
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= ATAN[i];
      end else begin
        x += ys; y -= xs; z += ATAN[i];
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint cordic_angle(longint x, longint y);
    longint z, xs, ys;
    z = 0;
    for (int i = 0; i < 30; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += ATAN[i];
      end else begin
        x -= ys; y += xs; z -= ATAN[i];
      end
    end
    return (z < 0) ? 0 : z;
  endfunction

  function automatic longint half_sin_sq(longint d);
    longint half, r, c, s;
    half = 64'd180 << ANGLE_FRAC_BITS;
    r = wrap_turn(d);
    if (r > half) r = 2 * half - r;
    cordic_rotate(deg_to_rad(r, 1), c, s);
    return floor_shift(s * s, 30);
  endfunction

  function automatic longint cos_of_deg(longint a);
    longint half, quarter, r, c, s;
    bit neg;
    half = 64'd180 << ANGLE_FRAC_BITS;
    quarter = 64'd90 << ANGLE_FRAC_BITS;
    neg = 1'b0;
    r = wrap_turn(a);
    if (r > half) r = 2 * half - r;
    if (r > quarter) begin
      r = half - r;
      neg = 1'b1;
    end
    cordic_rotate(deg_to_rad(r, 2), c, s);
    return neg ? -c : c;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [DIST_W-1:0] predict_distance(point_pair_t p,
                                                          logic [RADIUS_W-1:0] r);
    longint la, oa, lb, ob, slat, slon, cc, h, sn, cs, ang;
    longint unsigned dist_rnd;
    la = p.lat_a; oa = p.lon_a; lb = p.lat_b; ob = p.lon_b;
    slat = half_sin_sq(lb - la);
    slon = half_sin_sq(ob - oa);
    cc = floor_shift(cos_of_deg(la) * cos_of_deg(lb), 30);
    h = slat + floor_shift(cc * slon, 30);
    if (h < 0) h = 0;
    if (h > (64'd1 << 30)) h = 64'd1 << 30;
    sn = floor_root(longint'(h) << 30);
    cs = floor_root(longint'((64'd1 << 30) - h) << 30);
    ang = cordic_angle(cs, sn);
    dist_rnd = (64'd2 * r * longint'(ang) + (64'd1 << 13)) >> 14;
    return dist_rnd[DIST_W-1:0];
  endfunction

  function automatic bit idle_roll(bit active);
    int pct;
    pct = (idle_mode == IDLE_BOTH) ? 11 : 58;
    return active && ($urandom_range(99) < pct);
  endfunction

  // Driver: present requests from the pending queue at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o_seen) begin
        if (pending_q.size() != 0 && !hold_send &&
            !idle_roll(idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH)) begin
          lat_a_i <= pending_q[0].lat_a;
          lon_a_i <= pending_q[0].lon_a;
          lat_b_i <= pending_q[0].lat_b;
          lon_b_i <= pending_q[0].lon_b;
          dist_q = {dist_q, predict_distance(pending_q[0], radius)};
          void'(pending_q.pop_front());
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= !idle_roll(idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH);
    end
  end

  always @(posedge clk_i) in_ready_o_seen <= in_valid_i && in_ready_o;

  // Monitor: compare each result with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (dist_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", arc_distance_o);
      end else begin
        if (arc_distance_o !== dist_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("distance mismatch: expected %0d actual %0d",
                     dist_q[0], arc_distance_o);
        end
        void'(dist_q.pop_front());
      end
    end
  end

  function automatic logic [29:0] rand_lat();
    return 30'($signed(longint'($urandom_range(2 * LAT_MAX)) - LAT_MAX));
  endfunction

  function automatic logic [30:0] rand_lon();
    return 31'($signed(longint'($urandom_range(2 * LON_MAX)) - LON_MAX));
  endfunction

  function automatic point_pair_t rand_pair();
    point_pair_t p;
    int k;
    k = $urandom_range(9);
    if (k == 0) begin
      // raw bits over the whole field, beyond the stated range too
      p.lat_a = 30'($urandom); p.lon_a = 31'($urandom);
      p.lat_b = 30'($urandom); p.lon_b = 31'($urandom);
    end else if (k == 1) begin
      // near-coincident points
      p.lat_a = rand_lat(); p.lon_a = rand_lon();
      p.lat_b = p.lat_a + 30'($signed($urandom_range(2000)) - 1000);
      p.lon_b = p.lon_a + 31'($signed($urandom_range(2000)) - 1000);
    end else if (k == 2) begin
      // near-antipodal points
      p.lat_a = rand_lat(); p.lon_a = rand_lon();
      p.lat_b = -p.lat_a;
      p.lon_b = p.lon_a + 31'(180 << 22) + 31'($urandom_range(4000)) - 31'd2000;
    end else begin
      p.lat_a = rand_lat(); p.lon_a = rand_lon(); p.lat_b = rand_lat(); p.lon_b = rand_lon();
    end
    return p;
  endfunction

  task automatic add_pair(point_pair_t p);
    pending_q = {pending_q, p};
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || in_valid_i || dist_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 10) @(posedge clk_i);
  endtask

  task automatic write_radius(logic [RADIUS_W-1:0] r);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    earth_radius_i <= r;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    radius = r;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    point_pair_t p;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed corners at the reset radius
    p = '{30'(LAT_MAX), 31'(LON_MAX), 30'(-LAT_MAX), 31'(-LON_MAX)}; add_pair(p);
    p = '0; add_pair(p);
    p = '{30'(LAT_MAX), 31'd0, 30'(LAT_MAX), 31'd0}; add_pair(p);
    p = '{30'(LAT_MAX), 31'd0, 30'(-LAT_MAX), 31'd0}; add_pair(p);
    p = '{30'd0, 31'd0, 30'd0, 31'(180 << 22)}; add_pair(p);
    p = '{30'd0, 31'(-LON_MAX), 30'd0, 31'(LON_MAX)}; add_pair(p);
    p = '{30'h1fffffff, 31'h3fffffff, 30'h20000000, 31'h40000000}; add_pair(p);
    p = '{30'h20000000, 31'h40000000, 30'h1fffffff, 31'h3fffffff}; add_pair(p);
    p = '{30'(100 << 22), 31'd0, 30'(-100 << 22), 31'(90 << 22)}; add_pair(p);
    p = '{30'h3fffffff, 31'h7fffffff, 30'd1, 31'd1}; add_pair(p);
    p = '{30'(45 << 22), 31'(45 << 22), 30'(-45 << 22), 31'(-135 << 22)};
    add_pair(p);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      write_radius(RADII[ph]);
      idle_mode = idle_mode_e'(ph % 4);
      for (int n = 0; n < 280; n++) add_pair(rand_pair());
      if (ph == 2) begin
        // pause the sender until the pipeline has emptied
        while (pending_q.size() > 140) @(posedge clk_i);
        hold_send = 1'b1;
        while (in_valid_i || dist_q.size() != 0) @(posedge clk_i);
        hold_send = 1'b0;
      end
      drain();
    end
    if (mismatches == 0 && dist_q.size() == 0) begin
      $display("haversine_great_circle_distance test passed");
    end else begin
      $display("haversine_great_circle_distance test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("haversine_great_circle_distance test failed");
    $finish;
  end
endmodule
